### src/sensor_roi_mode_write_sequencer_top_macros.svh
// Assertion helpers used by the sequencer back end.
`ifndef SENSOR_ROI_MODE_WRITE_SEQUENCER_TOP_MACROS_SVH
`define SENSOR_ROI_MODE_WRITE_SEQUENCER_TOP_MACROS_SVH

// Checked on rising clk edges, disabled while rst is high.
`define SRMWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on rising clk edges, reset included.
`define SRMWS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/srmws_pkg.sv
`default_nettype none
package srmws_pkg;

  // Write limit per request and pixel array size.
  localparam int MAX_WRITES    = 64;
  localparam int ARRAY_COLUMNS = 8000;
  localparam int ARRAY_ROWS    = 6000;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_BIN    = 2'd1,
    ST_BAD_REGION = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    status_t     status;
    logic [2:0]  bin;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] xe;
    logic [15:0] ye;
    logic [15:0] ow;
    logic [15:0] oh;
  } cmd_t;

  // One result word.
  typedef struct packed {
    logic        write_valid;
    logic [15:0] reg_address;
    logic [7:0]  reg_value;
    logic [15:0] out_width;
    logic [15:0] out_height;
    status_t     status;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

### src/srmws_front.sv
`default_nettype none
module srmws_front (
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [15:0]        roi_x,
  input  wire logic [15:0]        roi_y,
  input  wire logic [15:0]        roi_width,
  input  wire logic [15:0]        roi_height,
  input  wire logic [7:0]         binning,
  output logic                    push_valid,
  input  wire logic               push_ready,
  output srmws_pkg::cmd_t         push_cmd
);

  localparam logic [16:0] COL_LIM = 17'(srmws_pkg::ARRAY_COLUMNS);
  localparam logic [16:0] ROW_LIM = 17'(srmws_pkg::ARRAY_ROWS);

  logic        bin_ok;
  logic [1:0]  align_mask;
  logic        misaligned;
  logic [16:0] x_end_excl;
  logic [16:0] y_end_excl;
  logic        region_bad;

  assign s_tready   = push_ready;
  assign push_valid = s_tvalid;

  // Checks and derived geometry
  always_comb begin
    bin_ok     = (binning == 8'd1) || (binning == 8'd2) || (binning == 8'd4);
    align_mask = (binning == 8'd4) ? 2'b11 : ((binning == 8'd2) ? 2'b01 : 2'b00);
    misaligned = |((roi_x[1:0] | roi_y[1:0] | roi_width[1:0] | roi_height[1:0])
                   & align_mask);
    x_end_excl = {1'b0, roi_x} + {1'b0, roi_width};
    y_end_excl = {1'b0, roi_y} + {1'b0, roi_height};
    region_bad = (roi_width == 16'd0) || (roi_height == 16'd0) || misaligned ||
                 (x_end_excl > COL_LIM) || (y_end_excl > ROW_LIM);

    push_cmd     = '0;
    push_cmd.bin = binning[2:0];
    push_cmd.x   = roi_x;
    push_cmd.y   = roi_y;
    push_cmd.xe  = x_end_excl[15:0] - 16'd1;
    push_cmd.ye  = y_end_excl[15:0] - 16'd1;
    if (!bin_ok) begin
      push_cmd.status = srmws_pkg::ST_BAD_BIN;
    end else if (region_bad) begin
      push_cmd.status = srmws_pkg::ST_BAD_REGION;
    end else begin
      push_cmd.status = srmws_pkg::ST_OK;
      // binning of 1, 2 or 4 is a plain shift
      case (binning)
        8'd4: begin
          push_cmd.ow = {2'b00, roi_width[15:2]};
          push_cmd.oh = {2'b00, roi_height[15:2]};
        end
        8'd2: begin
          push_cmd.ow = {1'b0, roi_width[15:1]};
          push_cmd.oh = {1'b0, roi_height[15:1]};
        end
        default: begin
          push_cmd.ow = roi_width;
          push_cmd.oh = roi_height;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### src/srmws_queue.sv
`default_nettype none
module srmws_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire srmws_pkg::cmd_t push_cmd,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output srmws_pkg::cmd_t      pop_cmd
);

  // two-entry queue between front and back
  srmws_pkg::cmd_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_cmd;
  end

endmodule
`default_nettype wire

### src/srmws_back.sv
`default_nettype none
`include "sensor_roi_mode_write_sequencer_top_macros.svh"
module srmws_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  output logic                 q_pop,
  input  wire srmws_pkg::cmd_t head,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output srmws_pkg::res_t      m_res
);

  localparam logic [8:0]  MAX_W9 = 9'(srmws_pkg::MAX_WRITES);

  // sensor register map
  localparam logic [15:0] REG_STREAM    = 16'h0100;
  localparam logic [15:0] REG_HOLD      = 16'h0104;
  localparam logic [15:0] REG_X_START   = 16'h0344;
  localparam logic [15:0] REG_Y_START   = 16'h0346;
  localparam logic [15:0] REG_X_END     = 16'h0348;
  localparam logic [15:0] REG_Y_END     = 16'h034a;
  localparam logic [15:0] REG_OUT_W     = 16'h034c;
  localparam logic [15:0] REG_OUT_H     = 16'h034e;
  localparam logic [15:0] REG_BIN_MODE  = 16'h0900;
  localparam logic [15:0] REG_BIN_TYPE  = 16'h0901;
  localparam logic [15:0] REG_BIN_WGT   = 16'h0902;
  localparam logic [15:0] REG_DCROP_X   = 16'h0408;
  localparam logic [15:0] REG_DCROP_Y   = 16'h040a;
  localparam logic [15:0] REG_DCROP_W   = 16'h040c;
  localparam logic [15:0] REG_DCROP_H   = 16'h040e;

  localparam logic [5:0]  TUNE_FIRST    = 6'd25;
  localparam logic [5:0]  TUNE_LAST     = 6'd34;
  localparam logic [5:0]  END_BIN1      = 6'd35;
  localparam logic [5:0]  END_BINN      = 6'd25;

  localparam logic [15:0] TUNE_ADDR [10] = '{
    16'h3246, 16'h3247, 16'h3620, 16'h3c13, 16'h3f0c,
    16'h3f14, 16'h3f80, 16'h3f81, 16'h3f8c, 16'h3f8d
  };
  localparam logic [7:0]  TUNE_VAL [10] = '{
    8'h01, 8'h01, 8'h00, 8'h2a, 8'h00,
    8'h01, 8'h02, 8'h00, 8'h01, 8'h00
  };

  // address and byte of write number idx, packed {address, value}
  function automatic logic [23:0] wr_lookup(input logic [5:0] idx,
                                            input srmws_pkg::cmd_t c);
    logic       bin1;
    logic [3:0] ti;
    logic [23:0] r;
    bin1 = (c.bin == 3'd1);
    ti   = 4'(idx - TUNE_FIRST);
    r    = '0;
    if (bin1 && (idx >= TUNE_FIRST) && (idx <= TUNE_LAST)) begin
      r = {TUNE_ADDR[ti], TUNE_VAL[ti]};
    end else begin
      case (idx)
        6'd0:  r = {REG_STREAM, 8'h00};
        6'd1:  r = {REG_HOLD, 8'h01};
        6'd2:  r = {REG_X_START, c.x[15:8]};
        6'd3:  r = {REG_X_START + 16'd1, c.x[7:0]};
        6'd4:  r = {REG_Y_START, c.y[15:8]};
        6'd5:  r = {REG_Y_START + 16'd1, c.y[7:0]};
        6'd6:  r = {REG_X_END, c.xe[15:8]};
        6'd7:  r = {REG_X_END + 16'd1, c.xe[7:0]};
        6'd8:  r = {REG_Y_END, c.ye[15:8]};
        6'd9:  r = {REG_Y_END + 16'd1, c.ye[7:0]};
        6'd10: r = {REG_BIN_MODE, bin1 ? 8'h00 : 8'h01};
        6'd11: r = {REG_BIN_TYPE, 1'b0, c.bin, 1'b0, c.bin};
        6'd12: r = {REG_BIN_WGT, bin1 ? 8'h0a : 8'h08};
        6'd13: r = {REG_DCROP_X, 8'h00};
        6'd14: r = {REG_DCROP_X + 16'd1, 8'h00};
        6'd15: r = {REG_DCROP_Y, 8'h00};
        6'd16: r = {REG_DCROP_Y + 16'd1, 8'h00};
        6'd17: r = {REG_DCROP_W, c.ow[15:8]};
        6'd18: r = {REG_DCROP_W + 16'd1, c.ow[7:0]};
        6'd19: r = {REG_DCROP_H, c.oh[15:8]};
        6'd20: r = {REG_DCROP_H + 16'd1, c.oh[7:0]};
        6'd21: r = {REG_OUT_W, c.ow[15:8]};
        6'd22: r = {REG_OUT_W + 16'd1, c.ow[7:0]};
        6'd23: r = {REG_OUT_H, c.oh[15:8]};
        6'd24: r = {REG_OUT_H + 16'd1, c.oh[7:0]};
        6'd25: r = {REG_HOLD, 8'h00};
        6'd35: r = {REG_HOLD, 8'h00};
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  logic [5:0]      idx;
  logic [5:0]      idx_next;
  logic [23:0]     wr;
  logic [5:0]      run_end;
  logic            at_limit;
  logic            out_load;
  srmws_pkg::res_t res;

  // Result for the current step of the head request
  always_comb begin
    wr       = wr_lookup(idx, head);
    run_end  = (head.bin == 3'd1) ? END_BIN1 : END_BINN;
    at_limit = ({3'b000, idx} == MAX_W9);
    res      = '0;
    if (head.status != srmws_pkg::ST_OK) begin
      res.status = head.status;
      res.last   = 1'b1;
    end else if (at_limit) begin
      res.out_width  = head.ow;
      res.out_height = head.oh;
      res.status     = srmws_pkg::ST_OVERFLOW;
      res.last       = 1'b1;
    end else begin
      res.write_valid = 1'b1;
      res.reg_address = wr[23:8];
      res.reg_value   = wr[7:0];
      res.out_width   = head.ow;
      res.out_height  = head.oh;
      res.status      = srmws_pkg::ST_OK;
      res.last        = (idx == run_end);
    end
  end

  // Output reg takes a queued word when empty or being drained
  assign out_load = q_valid && (!m_tvalid || m_tready);
  assign q_pop    = out_load && res.last;
  assign idx_next = q_pop ? 6'd0 : (out_load ? idx + 6'd1 : idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= 6'd0;
    end else begin
      idx <= idx_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) m_res <= res;
  end

  `SRMWS_ASSERT(a_pop_restarts, q_pop |=> (idx == 6'd0), "step count not cleared after request")
  `SRMWS_ASSERT(a_step_advances, (out_load && !res.last) |=> (idx == 6'($past(idx) + 6'd1)), "step count skipped")
  `SRMWS_ASSERT(a_error_single, (q_valid && (head.status != srmws_pkg::ST_OK)) |-> (idx == 6'd0), "rejected request mid-run")
  `SRMWS_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !m_tvalid, "output valid right after reset")

endmodule
`default_nettype wire

### src/sensor_roi_mode_write_sequencer_top.sv
// ROI mode write sequencer. Each input word is one region-of-interest request
// (x, y, width, height, binning). A checked request produces its sensor write
// run on the output stream, one byte write per word per cycle while the output is
// not stalled: 26 words for binning 2 or 4, 36 for binning 1, then the next request,
// if already queued, follows with no gap. A rejected request yields a single status
// word; a run cut at the write limit ends with one extra overflow word. The output
// rate is set by the back-end step counter, which walks the write table one entry
// per cycle while words are taken. The front end classifies a request in the cycle
// it arrives and parks it in a two-entry queue. The request being streamed holds one
// entry until its last word is loaded, so one further request is taken while a run
// is streaming. Output words are held in a register until taken.
`default_nettype none
module sensor_roi_mode_write_sequencer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // roi_x[15:0], roi_y[31:16], roi_width[47:32], roi_height[63:48], binning[71:64]
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // reg_address[15:0], reg_value[23:16], out_width[39:24], out_height[55:40], zero[63:56]
  output logic [63:0]      m_axis_tdata,
  // write_valid[0], status[2:1]
  output logic [2:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  logic            push_valid;
  logic            push_ready;
  srmws_pkg::cmd_t push_cmd;
  logic            pop_valid;
  logic            pop_ready;
  srmws_pkg::cmd_t pop_cmd;
  srmws_pkg::res_t res;

  srmws_front u_front (
    .s_tvalid   (s_axis_tvalid),
    .s_tready   (s_axis_tready),
    .roi_x      (s_axis_tdata[15:0]),
    .roi_y      (s_axis_tdata[31:16]),
    .roi_width  (s_axis_tdata[47:32]),
    .roi_height (s_axis_tdata[63:48]),
    .binning    (s_axis_tdata[71:64]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  srmws_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  srmws_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (pop_valid),
    .q_pop    (pop_ready),
    .head     (pop_cmd),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_res    (res)
  );

  // Output word packing
  assign m_axis_tdata = {8'h00, res.out_height, res.out_width, res.reg_value,
                         res.reg_address};
  assign m_axis_tuser = {res.status, res.write_valid};
  assign m_axis_tlast = res.last;

endmodule
`default_nettype wire
